>>> rtl/siha_pkg.sv
`timescale 1ns / 1ps
package siha_pkg;

    localparam int DEF_MEM_WORDS = 4096;
    localparam int STEP_W = 6;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OOS   = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;

    localparam logic [15:0] CHAINED_MARK = 16'hFFFF;

    // controller steps, also the command code seen by the datapath
    localparam logic [STEP_W-1:0] S_IDLE = 6'd0;
    localparam logic [STEP_W-1:0] S_DEC  = 6'd1;
    localparam logic [STEP_W-1:0] S_FT2  = 6'd2;
    localparam logic [STEP_W-1:0] S_SA   = 6'd3;
    localparam logic [STEP_W-1:0] S_SB   = 6'd4;
    localparam logic [STEP_W-1:0] S_SC   = 6'd5;
    localparam logic [STEP_W-1:0] S_BUMP = 6'd6;
    localparam logic [STEP_W-1:0] S_HIT  = 6'd7;
    localparam logic [STEP_W-1:0] S_UC1  = 6'd8;
    localparam logic [STEP_W-1:0] S_UC2  = 6'd9;
    localparam logic [STEP_W-1:0] S_UC3  = 6'd10;
    localparam logic [STEP_W-1:0] S_UI1  = 6'd11;
    localparam logic [STEP_W-1:0] S_UI2  = 6'd12;
    localparam logic [STEP_W-1:0] S_UI3  = 6'd13;
    localparam logic [STEP_W-1:0] S_UI4  = 6'd14;
    localparam logic [STEP_W-1:0] S_UI5  = 6'd15;
    localparam logic [STEP_W-1:0] S_UI6  = 6'd16;
    localparam logic [STEP_W-1:0] S_L0   = 6'd17;
    localparam logic [STEP_W-1:0] S_L1   = 6'd18;
    localparam logic [STEP_W-1:0] S_LE1  = 6'd19;
    localparam logic [STEP_W-1:0] S_LE2  = 6'd20;
    localparam logic [STEP_W-1:0] S_LL1  = 6'd21;
    localparam logic [STEP_W-1:0] S_LL2  = 6'd22;
    localparam logic [STEP_W-1:0] S_LL3  = 6'd23;
    localparam logic [STEP_W-1:0] S_LW0  = 6'd24;
    localparam logic [STEP_W-1:0] S_LW1  = 6'd25;
    localparam logic [STEP_W-1:0] S_LW2  = 6'd26;
    localparam logic [STEP_W-1:0] S_LC   = 6'd27;
    localparam logic [STEP_W-1:0] S_LC1  = 6'd28;
    localparam logic [STEP_W-1:0] S_LC2  = 6'd29;
    localparam logic [STEP_W-1:0] S_LC3  = 6'd30;
    localparam logic [STEP_W-1:0] S_LC4  = 6'd31;
    localparam logic [STEP_W-1:0] S_LI0  = 6'd32;
    localparam logic [STEP_W-1:0] S_LI1  = 6'd33;
    localparam logic [STEP_W-1:0] S_LI2  = 6'd34;
    localparam logic [STEP_W-1:0] S_LI3  = 6'd35;
    localparam logic [STEP_W-1:0] S_LI4  = 6'd36;
    localparam logic [STEP_W-1:0] S_FIN  = 6'd37;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              take;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic op_free;
        logic srch;
        logic free_ok;
        logic recycle;
        logic at_end;
        logic lt4;
        logic curr_zero;
        logic hit_eq;
        logic hit_stop;
        logic q_nz;
        logic right_nz;
        logic shh_zero;
        logic tp_lt_q;
        logic above_zero;
        logic walk_go;
        logic tp_eq_q;
    } t_flags;

endpackage

>>> rtl/siha_ctrl.sv
`timescale 1ns / 1ps
module siha_ctrl
    import siha_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    output logic   o_valid,
    input  logic   i_stall,
    input  t_flags i_flags,
    output t_cmd   o_cmd
);

    logic [STEP_W-1:0] r_state, n_state;
    logic              r_ovalid;
    logic              load_out;

    assign load_out = (r_state == S_FIN) && (!r_ovalid || !i_stall);
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;

    assign o_cmd.step     = r_state;
    assign o_cmd.take     = (r_state == S_IDLE) && i_valid;
    assign o_cmd.load_out = load_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_DEC;
            S_DEC: begin
                if (i_flags.n_zero) n_state = S_FIN;
                else if (i_flags.op_free) n_state = i_flags.free_ok ? S_FT2 : S_FIN;
                else n_state = i_flags.srch ? S_SA : S_BUMP;
            end
            S_FT2: n_state = (i_flags.recycle && !i_flags.at_end && !i_flags.lt4)
                             ? S_L0 : S_FIN;
            S_SA: n_state = i_flags.curr_zero ? S_BUMP : S_SB;
            S_SB: begin
                if (i_flags.hit_eq) n_state = S_HIT;
                else if (i_flags.hit_stop) n_state = S_BUMP;
                else n_state = S_SC;
            end
            S_SC:   n_state = S_SA;
            S_BUMP: n_state = S_FIN;
            S_HIT:  n_state = i_flags.q_nz ? S_UC1 : S_UI1;
            S_UC1:  n_state = S_UC2;
            S_UC2:  n_state = S_UC3;
            S_UC3:  n_state = S_FIN;
            S_UI1:  n_state = S_UI2;
            S_UI2:  n_state = S_UI3;
            S_UI3:  n_state = S_UI4;
            S_UI4:  n_state = i_flags.right_nz ? S_UI5 : S_FIN;
            S_UI5:  n_state = S_UI6;
            S_UI6:  n_state = S_FIN;
            S_L0:   n_state = i_flags.shh_zero ? S_LE1 : S_L1;
            S_LE1:  n_state = S_LE2;
            S_LE2:  n_state = S_FIN;
            S_L1:   n_state = i_flags.tp_lt_q ? S_LL1 : S_LW0;
            S_LL1:  n_state = S_LL2;
            S_LL2:  n_state = S_LL3;
            S_LL3:  n_state = S_FIN;
            S_LW0:  n_state = i_flags.above_zero ? S_LI0 : S_LW1;
            S_LW1: begin
                if (i_flags.walk_go) n_state = S_LW2;
                else if (i_flags.tp_eq_q) n_state = S_LC;
                else n_state = S_LI0;
            end
            S_LW2:  n_state = S_LW0;
            S_LC:   n_state = S_LC1;
            S_LC1:  n_state = S_LC2;
            S_LC2:  n_state = S_LC3;
            S_LC3:  n_state = S_LC4;
            S_LC4:  n_state = S_FIN;
            S_LI0:  n_state = S_LI1;
            S_LI1:  n_state = S_LI2;
            S_LI2:  n_state = S_LI3;
            S_LI3:  n_state = S_LI4;
            S_LI4:  n_state = S_FIN;
            S_FIN:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

endmodule

>>> rtl/siha_dp.sv
`timescale 1ns / 1ps
module siha_dp
    import siha_pkg::*;
#(
    parameter int MEM_WORDS = DEF_MEM_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_flags      o_flags,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_op,
    input  logic [11:0] i_run_words,
    input  logic [11:0] i_start_addr,
    input  logic        i_search_holes,
    output logic [11:0] o_granted_addr,
    output logic [1:0]  o_status,
    output logic [11:0] o_chain_steps,
    output logic [11:0] o_free_hole_words
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam bit POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam logic [16:0] MW17 = 17'(MEM_WORDS);
    localparam logic [AW:0] GUARD_MAX = (AW+1)'(MEM_WORDS);

    function automatic logic [AW-1:0] wrap(input logic [16:0] v);
        logic [16:0] d;
        d = v - MW17;
        if (POW2) return v[AW-1:0];
        else if (v >= MW17) return d[AW-1:0];
        else return v[AW-1:0];
    endfunction

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] r_q;
    logic [AW-1:0] rd_a, wa;
    logic [15:0] wd;
    logic we;

    logic        r_recycle;
    logic [AW-1:0] r_ep;
    logic [15:0] r_lhh, r_shh;
    logic [11:0] r_hwt;
    logic        r_op, r_search;
    logic [11:0] r_n, r_addr;
    logic [15:0] r_curr, r_above, r_below, r_right;
    logic [11:0] r_steps, r_grant;
    logic [1:0]  r_stat;
    logic [AW:0] r_guard;

    logic [16:0] ep_x, p_x, lastw_x, bump_sum;
    logic [12:0] lastw;
    logic [15:0] p16, tagn;
    logic signed [16:0] qs, negq, nn, tp;

    assign ep_x     = {{(17-AW){1'b0}}, r_ep};
    assign p16      = {4'b0, r_addr};
    assign p_x      = {5'b0, r_addr};
    assign lastw    = {1'b0, r_addr} + {1'b0, r_n} - 13'd1;
    assign lastw_x  = {4'b0, lastw};
    assign bump_sum = ep_x + {5'b0, r_n};
    assign tagn     = 16'd0 - {4'b0, r_n};
    assign qs       = $signed({r_q[15], r_q});
    assign negq     = -qs;
    assign nn       = $signed({5'b0, r_n});
    assign tp       = -nn;

    assign o_flags.n_zero     = (r_n == 12'd0);
    assign o_flags.op_free    = (r_op == OP_FREE);
    assign o_flags.srch       = r_search && r_recycle;
    assign o_flags.free_ok    = (r_addr != 12'd0) && (lastw_x <= ep_x);
    assign o_flags.recycle    = r_recycle;
    assign o_flags.at_end     = (lastw_x == ep_x);
    assign o_flags.lt4        = (r_n < 12'd4);
    assign o_flags.curr_zero  = (r_curr == 16'd0);
    assign o_flags.hit_eq     = (nn == negq);
    assign o_flags.hit_stop   = (nn < negq) || (r_guard >= GUARD_MAX);
    assign o_flags.q_nz       = (r_q != 16'd0);
    assign o_flags.right_nz   = (r_right != 16'd0);
    assign o_flags.shh_zero   = (r_shh == 16'd0);
    assign o_flags.tp_lt_q    = (tp < qs);
    assign o_flags.above_zero = (r_above == 16'd0);
    assign o_flags.walk_go    = (tp < qs) && (r_guard < GUARD_MAX);
    assign o_flags.tp_eq_q    = (tp == qs);

    function automatic logic [16:0] plus(input logic [15:0] b, input logic [1:0] k);
        return {1'b0, b} + {15'd0, k};
    endfunction

    // memory port: one read address, one write per step
    always_comb begin
        rd_a = '0;
        we   = 1'b0;
        wa   = '0;
        wd   = '0;
        unique case (i_cmd.step)
            S_DEC: begin
                if (r_op == OP_FREE && r_n != 12'd0 && o_flags.free_ok) begin
                    we = 1'b1; wa = wrap(p_x); wd = tagn;
                end
            end
            S_FT2: begin we = 1'b1; wa = wrap(lastw_x); wd = tagn; end
            S_SA:  rd_a = wrap({1'b0, r_curr});
            S_SB:  rd_a = wrap(plus(r_curr, o_flags.hit_eq ? 2'd3 : 2'd1));
            S_HIT: rd_a = o_flags.q_nz ? wrap(plus(r_q, 2'd2)) : wrap(plus(r_curr, 2'd1));
            S_UC1: rd_a = wrap(plus(r_curr, 2'd3));
            S_UC2: begin we = 1'b1; wa = wrap(plus(r_below, 2'd3)); wd = r_q; end
            S_UC3: begin
                we = (r_right != 16'd0); wa = wrap(plus(r_right, 2'd2)); wd = r_below;
            end
            S_UI1: rd_a = wrap(plus(r_curr, 2'd2));
            S_UI2: rd_a = wrap(plus(r_curr, 2'd3));
            S_UI3: begin
                if (r_q != 16'd0) begin
                    we = 1'b1; wa = wrap(plus(r_q, 2'd1)); wd = r_above;
                end else begin
                    we = (r_above != 16'd0); wa = wrap(plus(r_above, 2'd2)); wd = r_below;
                end
            end
            S_UI4: begin
                if (r_right != 16'd0) begin
                    we = 1'b1; wa = wrap(plus(r_right, 2'd2)); wd = r_below;
                end else begin
                    we = (r_below != 16'd0); wa = wrap(plus(r_below, 2'd1)); wd = r_above;
                end
            end
            S_UI5: begin
                we = (r_above != 16'd0); wa = wrap(plus(r_above, 2'd2)); wd = r_right;
            end
            S_UI6: begin
                we = (r_below != 16'd0); wa = wrap(plus(r_below, 2'd1)); wd = r_right;
            end
            S_L0: begin
                if (r_shh == 16'd0) begin
                    we = 1'b1; wa = wrap(plus(p16, 2'd1)); wd = 16'd0;
                end else begin
                    rd_a = wrap({1'b0, r_lhh});
                end
            end
            S_LE1: begin we = 1'b1; wa = wrap(plus(p16, 2'd2)); wd = 16'd0; end
            S_LE2: begin we = 1'b1; wa = wrap(plus(p16, 2'd3)); wd = 16'd0; end
            S_L1: begin
                we = o_flags.tp_lt_q; wa = wrap(plus(p16, 2'd1)); wd = 16'd0;
            end
            S_LL1: begin we = 1'b1; wa = wrap(plus(p16, 2'd3)); wd = 16'd0; end
            S_LL2: begin we = 1'b1; wa = wrap(plus(p16, 2'd2)); wd = r_lhh; end
            S_LL3: begin we = 1'b1; wa = wrap(plus(r_lhh, 2'd1)); wd = p16; end
            S_LW0: rd_a = wrap({1'b0, r_above});
            S_LW1: rd_a = wrap(plus(r_above, o_flags.walk_go ? 2'd1 : 2'd3));
            S_LC:  begin we = 1'b1; wa = wrap(plus(p16, 2'd1)); wd = CHAINED_MARK; end
            S_LC1: begin we = 1'b1; wa = wrap(plus(p16, 2'd2)); wd = r_above; end
            S_LC2: begin we = 1'b1; wa = wrap(plus(p16, 2'd3)); wd = r_right; end
            S_LC3: begin
                we = (r_right != 16'd0); wa = wrap(plus(r_right, 2'd2)); wd = p16;
            end
            S_LC4: begin we = 1'b1; wa = wrap(plus(r_above, 2'd3)); wd = p16; end
            S_LI0: begin we = 1'b1; wa = wrap(plus(p16, 2'd1)); wd = r_above; end
            S_LI1: begin we = 1'b1; wa = wrap(plus(p16, 2'd2)); wd = r_below; end
            S_LI2: begin we = 1'b1; wa = wrap(plus(p16, 2'd3)); wd = 16'd0; end
            S_LI3: begin
                we = (r_above != 16'd0); wa = wrap(plus(r_above, 2'd2)); wd = p16;
            end
            S_LI4: begin
                we = (r_below != 16'd0); wa = wrap(plus(r_below, 2'd1)); wd = p16;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_q <= mem[rd_a];
    end

    // grid heads, end pointer and hole count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recycle <= 1'b1;
            r_ep      <= '0;
            r_lhh     <= '0;
            r_shh     <= '0;
            r_hwt     <= '0;
        end else begin
            if (i_cfg_we) r_recycle <= i_cfg_wdata;
            unique case (i_cmd.step)
                S_DEC: if (r_op == OP_FREE && r_n != 12'd0 && o_flags.free_ok)
                    r_hwt <= r_hwt + r_n;
                S_FT2: if (r_recycle && o_flags.at_end) begin
                    r_ep  <= AW'(ep_x - {5'b0, r_n});
                    r_hwt <= r_hwt - r_n;
                end
                S_BUMP: if (bump_sum < MW17) r_ep <= bump_sum[AW-1:0];
                S_HIT: r_hwt <= r_hwt - r_n;
                S_UI3: if (r_q == 16'd0 && r_above == 16'd0) r_lhh <= r_below;
                S_UI4: if (r_right == 16'd0 && r_below == 16'd0) r_shh <= r_above;
                S_UI5: if (r_above == 16'd0) r_lhh <= r_right;
                S_UI6: if (r_below == 16'd0) r_shh <= r_right;
                S_LE2: begin r_lhh <= p16; r_shh <= p16; end
                S_LL3: r_lhh <= p16;
                S_LI3: if (r_above == 16'd0) r_lhh <= p16;
                S_LI4: if (r_below == 16'd0) r_shh <= p16;
                default: ;
            endcase
        end
    end

    // per-transaction working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op     <= i_op;
            r_n      <= i_run_words;
            r_addr   <= i_start_addr;
            r_search <= i_search_holes;
        end
        unique case (i_cmd.step)
            S_DEC: begin
                r_grant <= '0;
                r_stat  <= STAT_OK;
                r_steps <= '0;
                r_guard <= '0;
                r_curr  <= r_shh;
            end
            S_FT2: if (r_recycle && !o_flags.at_end && o_flags.lt4) r_stat <= STAT_SHORT;
            S_SC: begin
                r_curr  <= r_q;
                r_steps <= r_steps + 12'd1;
                r_guard <= r_guard + 1'b1;
            end
            S_BUMP: begin
                if (bump_sum >= MW17) r_stat <= STAT_OOS;
                else r_grant <= 12'(ep_x + 17'd1);
            end
            S_HIT: begin
                if (r_q != 16'd0) begin
                    r_grant <= r_q[11:0];
                    r_curr  <= r_q;
                end else begin
                    r_grant <= r_curr[11:0];
                end
            end
            S_UC1: r_below <= r_q;
            S_UC2: r_right <= r_q;
            S_UI1: r_above <= r_q;
            S_UI2: r_below <= r_q;
            S_UI3: r_right <= r_q;
            S_L1: begin
                r_above <= r_shh;
                r_below <= '0;
                r_guard <= '0;
            end
            S_LW1: if (o_flags.walk_go) r_below <= r_above;
            S_LW2: begin
                r_above <= r_q;
                r_guard <= r_guard + 1'b1;
            end
            S_LC: r_right <= r_q;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_granted_addr    <= r_grant;
            o_status          <= r_stat;
            o_chain_steps     <= r_steps;
            o_free_hole_words <= r_hwt;
        end
    end

endmodule

>>> rtl/size_indexed_hole_allocator.sv
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// request   in         i_valid / o_stall  i_op, i_run_words, i_start_addr, i_search_holes
// result    out        o_valid / i_stall  o_granted_addr, o_status, o_chain_steps,
//                                         o_free_hole_words
// One transaction at a time; the word memory has one read and one write port.
// Bump allocate and short free go straight to the result. Exact-fit search reads
// each index hole passed, then unlinks the hit. Linked free walks the index holes
// and then links the new hole. Reset is synchronous and needs no clearing pass.
// The next request is taken while a result still waits under i_stall.
module size_indexed_hole_allocator
    import siha_pkg::*;
#(
    parameter int MEM_WORDS = DEF_MEM_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [11:0] i_run_words,
    input  logic [11:0] i_start_addr,
    input  logic        i_search_holes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_granted_addr,
    output logic [1:0]  o_status,
    output logic [11:0] o_chain_steps,
    output logic [11:0] o_free_hole_words
);

    t_cmd   cmd;
    t_flags flags;

    siha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_flags (flags),
        .o_cmd   (cmd)
    );

    siha_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_flags           (flags),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (i_op),
        .i_run_words       (i_run_words),
        .i_start_addr      (i_start_addr),
        .i_search_holes    (i_search_holes),
        .o_granted_addr    (o_granted_addr),
        .o_status          (o_status),
        .o_chain_steps     (o_chain_steps),
        .o_free_hole_words (o_free_hole_words)
    );

endmodule

>>> rtl/siha_chk.sv
`timescale 1ns / 1ps
module siha_chk
    import siha_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [11:0] o_granted_addr,
    input logic [1:0]  o_status,
    input logic [11:0] o_chain_steps
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_granted_addr) && $stable(o_status))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("unknown status code");

    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_OOS || o_status == STAT_SHORT) |-> o_granted_addr == 12'd0)
        else $error("address granted on a failed or short transaction");

    a_short_nosearch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_SHORT |-> o_chain_steps == 12'd0)
        else $error("search steps reported on a free");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while the previous one is in progress");

endmodule

bind size_indexed_hole_allocator siha_chk u_siha_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_granted_addr (o_granted_addr),
    .o_status       (o_status),
    .o_chain_steps  (o_chain_steps)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import siha_pkg::*;

    localparam int WORDS = DEF_MEM_WORDS;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        bit [11:0] granted;
        bit [1:0]  status;
        bit [11:0] steps;
        bit [11:0] hole_total;
    } alloc_result_t;

    typedef struct {
        bit [11:0] addr;
        bit [11:0] words;
    } live_run_t;

    class hole_scoreboard;
        bit [15:0] mem_words[WORDS];
        int unsigned end_ptr, big_head, small_head, longest;
        bit [11:0] hole_total;
        bit        recycle;
        alloc_result_t expected_q[$];
        int mismatches, checked, n_oos, n_short, n_hits, n_frees;

        function new();
            foreach (mem_words[i]) mem_words[i] = 16'h0;
            end_ptr = 0; big_head = 0; small_head = 0;
            hole_total = 0; longest = 0; recycle = 1'b1;
        endfunction

        function int unsigned rd(int unsigned a);
            return mem_words[a % WORDS];
        endfunction

        function void wr(int unsigned a, int unsigned v);
            mem_words[a % WORDS] = v[15:0];
        endfunction

        function int tag_of(int unsigned a);
            return int'($signed(mem_words[a % WORDS]));
        endfunction

        function void unlink_chained(int unsigned h);
            int unsigned lft, rgt;
            lft = rd(h + 2);
            rgt = rd(h + 3);
            wr(lft + 3, rgt);
            if (rgt != 0) wr(rgt + 2, lft);
        endfunction

        function void unlink_index(int unsigned h);
            int unsigned up, down, rgt;
            up = rd(h + 1);
            down = rd(h + 2);
            rgt = rd(h + 3);
            if (rgt != 0) begin
                wr(rgt + 1, up);
                wr(rgt + 2, down);
                if (up != 0) wr(up + 2, rgt); else big_head = rgt;
                if (down != 0) wr(down + 1, rgt); else small_head = rgt;
                return;
            end
            if (up != 0) wr(up + 2, down); else big_head = down;
            if (down != 0) wr(down + 1, up); else small_head = up;
        endfunction

        function void link_hole(int unsigned p);
            int tp;
            int unsigned up, down, guard, rgt;
            tp = tag_of(p);
            if (small_head == 0) begin
                wr(p + 1, 0); wr(p + 2, 0); wr(p + 3, 0);
                big_head = p; small_head = p;
                return;
            end
            if (tp < tag_of(big_head)) begin
                wr(p + 1, 0); wr(p + 3, 0);
                wr(p + 2, big_head);
                wr(big_head + 1, p);
                big_head = p;
                return;
            end
            up = small_head;
            down = 0;
            guard = 0;
            while (up != 0 && tp < tag_of(up) && guard < WORDS) begin
                down = up;
                up = rd(down + 1);
                guard++;
            end
            if (up != 0 && tp == tag_of(up)) begin
                rgt = rd(up + 3);
                wr(p + 1, CHAINED_MARK);
                wr(p + 2, up);
                wr(p + 3, rgt);
                if (rgt != 0) wr(rgt + 2, p);
                wr(up + 3, p);
                return;
            end
            wr(p + 1, up);
            wr(p + 2, down);
            wr(p + 3, 0);
            if (up != 0) wr(up + 2, p); else big_head = p;
            if (down != 0) wr(down + 1, p); else small_head = p;
        endfunction

        // Predict the result of one accepted transaction and queue it.
        function alloc_result_t note_request(bit op, bit [11:0] n, bit [11:0] addr, bit srch);
            alloc_result_t r;
            int unsigned curr, guard, nxt, lastw, steps;
            int t;
            bit done;
            r.granted = 0; r.status = STAT_OK; steps = 0;
            if (n == 0) begin
            end else if (op == OP_ALLOC) begin
                done = 0;
                if (srch && recycle) begin
                    curr = small_head;
                    guard = 0;
                    while (curr != 0) begin
                        t = tag_of(curr);
                        if (int'(n) == -t) break;
                        if (int'(n) < -t || guard >= WORDS) begin
                            curr = 0;
                            break;
                        end
                        curr = rd(curr + 1);
                        steps++;
                        guard++;
                    end
                    steps = steps % 4096;
                    if (steps > longest) longest = steps;
                    if (curr != 0) begin
                        nxt = rd(curr + 3);
                        hole_total = hole_total - n;
                        if (nxt != 0) begin
                            unlink_chained(nxt);
                            r.granted = 12'(nxt);
                        end else begin
                            unlink_index(curr);
                            r.granted = 12'(curr);
                        end
                        done = 1;
                        n_hits++;
                    end
                end
                if (!done) begin
                    if (int'(end_ptr) + int'(n) >= WORDS) begin
                        r.status = STAT_OOS;
                        n_oos++;
                    end else begin
                        r.granted = 12'(end_ptr + 1);
                        end_ptr = end_ptr + n;
                    end
                end
            end else begin
                lastw = addr + n - 1;
                if (addr != 0 && lastw <= end_ptr) begin
                    n_frees++;
                    hole_total = hole_total + n;
                    wr(addr, 32'h10000 - n);
                    wr(lastw, 32'h10000 - n);
                    if (recycle) begin
                        if (lastw == end_ptr) begin
                            end_ptr = end_ptr - n;
                            hole_total = hole_total - n;
                        end else if (n < 4) begin
                            r.status = STAT_SHORT;
                            n_short++;
                        end else begin
                            link_hole(addr);
                        end
                    end
                end
            end
            r.steps = steps[11:0];
            r.hole_total = hole_total;
            expected_q.push_back(r);
            return r;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_result(bit [11:0] g, bit [1:0] s, bit [11:0] c, bit [11:0] f);
            alloc_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result addr=%0d status=%0d", g, s));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (g !== e.granted)
                report($sformatf("granted_addr exp %0d got %0d", e.granted, g));
            if (s !== e.status)
                report($sformatf("status exp %0d got %0d", e.status, s));
            if (c !== e.steps)
                report($sformatf("chain_steps exp %0d got %0d", e.steps, c));
            if (f !== e.hole_total)
                report($sformatf("free_hole_words exp %0d got %0d", e.hole_total, f));
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_cfg_we, i_cfg_wdata;
    logic        i_valid, o_stall, i_op, i_search_holes;
    logic [11:0] i_run_words, i_start_addr;
    logic        o_valid, i_stall;
    logic [11:0] o_granted_addr, o_chain_steps, o_free_hole_words;
    logic [1:0]  o_status;

    hole_scoreboard sb;
    live_run_t      live_runs[$];
    bit             hold_req;
    int             cycles;

    size_indexed_hole_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_run_words(i_run_words), .i_start_addr(i_start_addr),
        .i_search_holes(i_search_holes),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_granted_addr(o_granted_addr), .o_status(o_status),
        .o_chain_steps(o_chain_steps), .o_free_hole_words(o_free_hole_words)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_granted_addr, o_status, o_chain_steps, o_free_hole_words);
    end

    // Result side back-pressure; a hold request stalls for a long stretch.
    initial begin
        int r, len;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_stall <= 1'b0;
                    len = $urandom_range(1, 20);
                end else begin
                    i_stall <= 1'b1;
                    len = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end
                repeat (len) @(negedge i_clk);
            end
        end
    end

    // Call at a falling edge; returns at a falling edge.
    task automatic issue(bit op, bit [11:0] n, bit [11:0] addr, bit srch);
        alloc_result_t r;
        int pick, gap;
        i_valid <= 1'b1;
        i_op <= op;
        i_run_words <= n;
        i_start_addr <= addr;
        i_search_holes <= srch;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        r = sb.note_request(op, n, addr, srch);
        if (op == OP_ALLOC && r.status == STAT_OK && r.granted != 0)
            live_runs.push_back('{r.granted, n});
        @(negedge i_clk);
        pick = $urandom_range(0, 99);
        gap = (pick < 40) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic free_live(int idx);
        live_run_t lr;
        lr = live_runs[idx];
        live_runs.delete(idx);
        issue(OP_FREE, lr.words, lr.addr, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_recycle(bit v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.recycle = v;
    endtask

    task automatic random_item();
        int r, a, n;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            issue(1'($urandom_range(0, 1)), 12'd0, 12'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
        end else if (r < 7) begin
            // out-of-range free: drop the address to null if it would hit a real run
            a = $urandom_range(0, 4095);
            n = $urandom_range(1, 4095);
            if (a != 0 && a + n - 1 <= sb.end_ptr) a = 0;
            issue(OP_FREE, 12'(n), 12'(a), 1'($urandom_range(0, 1)));
        end else if (r < 10) begin
            issue(OP_ALLOC, 12'($urandom_range(1, 4095)), 12'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
        end else if (r < 55 || live_runs.size() == 0) begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 60);
            issue(OP_ALLOC, 12'(n), 12'($urandom_range(0, 4095)), $urandom_range(0, 9) < 8);
        end else begin
            free_live($urandom_range(0, live_runs.size() - 1));
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_valid = 1'b0;
        i_op = OP_ALLOC;
        i_run_words = '0;
        i_start_addr = '0;
        i_search_holes = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_recycle(1'b1);

        // directed: index and chained holes, short hole, end pullback, odd requests
        issue(OP_ALLOC, 4, 0, 1); issue(OP_ALLOC, 4, 0, 1); issue(OP_ALLOC, 4, 0, 1);
        issue(OP_ALLOC, 4, 0, 1); issue(OP_ALLOC, 6, 0, 1); issue(OP_ALLOC, 6, 0, 0);
        issue(OP_ALLOC, 2, 0, 1); issue(OP_ALLOC, 5, 0, 1); issue(OP_ALLOC, 3, 0, 1);
        free_live(1);
        free_live(2);
        free_live(3);
        free_live(4);
        free_live(3);
        issue(OP_ALLOC, 4, 12'hFFF, 1);
        issue(OP_ALLOC, 4, 0, 1);
        issue(OP_ALLOC, 6, 0, 0);
        issue(OP_ALLOC, 6, 0, 1);
        free_live(live_runs.size() - 1);
        issue(OP_ALLOC, 0, 0, 1);
        issue(OP_FREE, 0, 5, 0);
        issue(OP_FREE, 4, 0, 1);
        issue(OP_FREE, 50, 4000, 0);
        issue(OP_ALLOC, 4095, 0, 1);
        issue(OP_ALLOC, 4095, 0, 0);

        repeat (350) random_item();
        wait_idle();
        write_recycle(1'b0);
        repeat (150) random_item();
        wait_idle();
        write_recycle(1'b1);
        repeat (100) random_item();
        hold_req = 1'b1;
        repeat (300) random_item();

        wait_idle();
        repeat (60) @(negedge i_clk);
        $display("%0d results checked: %0d holes reused, %0d out of space, %0d short holes",
                 sb.checked, sb.n_hits, sb.n_oos, sb.n_short);
        $display("%0d frees applied, longest exact-fit search %0d, %0d cycles",
                 sb.n_frees, sb.longest, cycles);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
